### rtl/hit_or_miss_thinning_pass_macros.svh
// assertion macros for the port checker of the thinning pass
// no dependencies; include by bare file name
`ifndef HIT_OR_MISS_THINNING_PASS_MACROS_SVH
`define HIT_OR_MISS_THINNING_PASS_MACROS_SVH

// concurrent assertion, disabled while reset is high
`define HMT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that is also checked during reset
`define HMT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hmt_pkg.sv
// types, constants and template match function of the thinning pass
// used by every module of the block; no dependencies
package hmt_pkg;

  // geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // field widths of the ports
  localparam int PIX_W        = 8;
  localparam int TPL_W        = 18;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 18;
  localparam int NUM_TPL      = 4;
  localparam int MIN_DIM      = 3;

  typedef logic [PIX_W-1:0]            pix_t;
  typedef logic [TPL_W-1:0]            tpl_t;
  typedef logic [NUM_TPL-1:0][TPL_W-1:0] tpl_set_t;
  typedef logic [8:0][PIX_W-1:0]       win_t;   // index row*3 + column
  typedef logic [COL_W-1:0]            col_t;
  typedef logic [ROW_W-1:0]            row_t;

  localparam pix_t WHITE = 8'd255;
  localparam pix_t BLACK = 8'd0;

  // template cell encoding
  localparam int CELL_DONT_CARE_BIT = 1;
  localparam int CELL_BLACK_BIT     = 0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMPLATE_A   = 3'd0,
    REG_TEMPLATE_B   = 3'd1,
    REG_TEMPLATE_C   = 3'd2,
    REG_TEMPLATE_D   = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } cfg_reg_t;

  // one pixel on its way from the input register to the result register
  typedef struct packed {
    pix_t px;
    col_t col;
    logic has_result;
    logic interior;
    logic last;
  } item_t;

  // decision for one center pixel
  typedef struct packed {
    pix_t pixel;
    logic remove;
  } match_t;

  // ternary template against a 3x3 window; an all don't-care template misses
  function automatic logic tpl_hit(input tpl_t tpl, input win_t win);
    logic       any_cell;
    logic       ok;
    logic [1:0] cell_code;
    any_cell = 1'b0;
    ok       = 1'b1;
    for (int k = 0; k < 9; k++) begin
      cell_code = tpl[2*k +: 2];
      if (!cell_code[CELL_DONT_CARE_BIT]) begin
        any_cell = 1'b1;
        if (cell_code[CELL_BLACK_BIT]) begin
          if (win[k] != BLACK) ok = 1'b0;
        end else begin
          if (win[k] != WHITE) ok = 1'b0;
        end
      end
    end
    return any_cell && ok;
  endfunction

endpackage

### rtl/hit_or_miss_thinning_pass.sv
// One pass of 3x3 hit-or-miss thinning over a raster-order 8-bit image. The block takes
// one pixel per clock and returns one result per clock once the first row and column
// have passed, unless the output stalls; the result for (r-1,c-1) enters the output
// register as pixel (r,c) leaves the input register. The rate is set by the two line
// memories, each read once and written once per pixel. They need no clearing after reset,
// since every result reads only rows of the current frame. The last result of a frame
// carries frame_done and any_removed; rerun passes while any_removed is set. Write the
// templates and geometry only while the block is idle; a geometry write restarts the frame.
// depends on hmt_pkg, hmt_line_store, hmt_window_match
module hit_or_miss_thinning_pass (
  input  logic                               clk,
  input  logic                               rst,
  // pixel input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  hmt_pkg::pix_t                      pixel_in,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output hmt_pkg::pix_t                      pixel_out,
  output logic                               frame_done,
  output logic                               any_removed,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hmt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hmt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration
  hmt_pkg::tpl_set_t tpls;
  hmt_pkg::col_t     col_last;
  hmt_pkg::row_t     row_last;
  logic              cfg_wr;
  logic              geom_wr;
  logic [hmt_pkg::WIDTH_REG_W-1:0]  width_val;
  logic [hmt_pkg::HEIGHT_REG_W-1:0] height_val;
  hmt_pkg::col_t     col_last_next;
  hmt_pkg::row_t     row_last_next;

  // position counters
  hmt_pkg::col_t col_count;
  hmt_pkg::row_t row_count;

  // pipeline
  logic            in_accept;
  logic            s1_valid;
  logic            s1_adv;
  hmt_pkg::item_t  s1_item;
  hmt_pkg::item_t  item_next;
  hmt_pkg::pix_t   rd_upper;
  hmt_pkg::pix_t   rd_lower;
  hmt_pkg::match_t match;
  logic            removed;
  logic            removed_now;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign geom_wr   = cfg_wr && (cfg_index == hmt_pkg::REG_IMAGE_WIDTH ||
                                cfg_index == hmt_pkg::REG_IMAGE_HEIGHT);

  // clamp geometry to its legal range, kept as last column and last row
  always_comb begin
    width_val  = cfg_data[hmt_pkg::WIDTH_REG_W-1:0];
    height_val = cfg_data[hmt_pkg::HEIGHT_REG_W-1:0];
    if (int'(width_val) < hmt_pkg::MIN_DIM) begin
      col_last_next = hmt_pkg::COL_W'(hmt_pkg::MIN_DIM - 1);
    end else if (int'(width_val) > hmt_pkg::MAX_WIDTH) begin
      col_last_next = hmt_pkg::COL_W'(hmt_pkg::MAX_WIDTH - 1);
    end else begin
      col_last_next = hmt_pkg::COL_W'(width_val - 1'b1);
    end
    if (int'(height_val) < hmt_pkg::MIN_DIM) begin
      row_last_next = hmt_pkg::ROW_W'(hmt_pkg::MIN_DIM - 1);
    end else if (int'(height_val) > hmt_pkg::MAX_HEIGHT) begin
      row_last_next = hmt_pkg::ROW_W'(hmt_pkg::MAX_HEIGHT - 1);
    end else begin
      row_last_next = hmt_pkg::ROW_W'(height_val - 1'b1);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tpls     <= '0;
      col_last <= hmt_pkg::COL_W'(1024 - 1);
      row_last <= hmt_pkg::ROW_W'(1024 - 1);
    end else if (cfg_wr) begin
      unique case (hmt_pkg::cfg_reg_t'(cfg_index))
        hmt_pkg::REG_TEMPLATE_A:   tpls[0]  <= cfg_data[hmt_pkg::TPL_W-1:0];
        hmt_pkg::REG_TEMPLATE_B:   tpls[1]  <= cfg_data[hmt_pkg::TPL_W-1:0];
        hmt_pkg::REG_TEMPLATE_C:   tpls[2]  <= cfg_data[hmt_pkg::TPL_W-1:0];
        hmt_pkg::REG_TEMPLATE_D:   tpls[3]  <= cfg_data[hmt_pkg::TPL_W-1:0];
        hmt_pkg::REG_IMAGE_WIDTH:  col_last <= col_last_next;
        hmt_pkg::REG_IMAGE_HEIGHT: row_last <= row_last_next;
        default: ;
      endcase
    end
  end

  // handshake: the input register moves on when the result register is free
  assign s1_adv    = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // raster position of the arriving pixel
  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      if (col_count == col_last) begin
        col_count <= '0;
        row_count <= (row_count == row_last) ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // what the pixel needs to know about its place in the frame
  always_comb begin
    item_next.px         = pixel_in;
    item_next.col        = col_count;
    item_next.has_result = (row_count != '0) && (col_count != '0);
    item_next.interior   = (row_count > hmt_pkg::ROW_W'(1)) && (col_count > hmt_pkg::COL_W'(1));
    item_next.last       = (row_count == row_last) && (col_count == col_last);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= item_next;
    end
  end

  hmt_line_store u_lines (
    .clk      (clk),
    .rd_en    (in_accept),
    .rd_addr  (col_count),
    .wr_en    (s1_adv),
    .wr_addr  (s1_item.col),
    .wr_upper (rd_lower),
    .wr_lower (s1_item.px),
    .rd_upper (rd_upper),
    .rd_lower (rd_lower)
  );

  hmt_window_match u_match (
    .clk      (clk),
    .shift_en (s1_adv),
    .tpls     (tpls),
    .col_top  (rd_upper),
    .col_mid  (rd_lower),
    .col_bot  (s1_item.px),
    .interior (s1_item.interior),
    .result   (match)
  );

  // removal seen so far in this frame, including this pixel
  assign removed_now = removed || match.remove;

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      removed <= 1'b0;
    end else if (s1_adv) begin
      removed <= s1_item.last ? 1'b0 : removed_now;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_item.has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_item.has_result) begin
      pixel_out   <= match.pixel;
      frame_done  <= s1_item.last;
      any_removed <= s1_item.last && removed_now;
    end
  end

endmodule

### rtl/hmt_line_store.sv
// two line memories holding the previous two image rows by column
// depends on hmt_pkg
module hmt_line_store (
  input  logic          clk,
  input  logic          rd_en,
  input  hmt_pkg::col_t rd_addr,
  input  logic          wr_en,
  input  hmt_pkg::col_t wr_addr,
  input  hmt_pkg::pix_t wr_upper,
  input  hmt_pkg::pix_t wr_lower,
  output hmt_pkg::pix_t rd_upper,
  output hmt_pkg::pix_t rd_lower
);

  hmt_pkg::pix_t upper_mem [hmt_pkg::MAX_WIDTH];
  hmt_pkg::pix_t lower_mem [hmt_pkg::MAX_WIDTH];

  // registered read, held while the reading pixel waits
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper <= upper_mem[rd_addr];
      rd_lower <= lower_mem[rd_addr];
    end
  end

  // rows move down one line store as the pixel leaves
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr] <= wr_upper;
      lower_mem[wr_addr] <= wr_lower;
    end
  end

endmodule

### rtl/hmt_window_match.sv
// 3x3 window shift register and the four template compares
// depends on hmt_pkg
module hmt_window_match (
  input  logic              clk,
  input  logic              shift_en,
  input  hmt_pkg::tpl_set_t tpls,
  input  hmt_pkg::pix_t     col_top,
  input  hmt_pkg::pix_t     col_mid,
  input  hmt_pkg::pix_t     col_bot,
  input  logic              interior,
  output hmt_pkg::match_t   result
);

  hmt_pkg::win_t win;
  hmt_pkg::win_t win_next;
  logic [hmt_pkg::NUM_TPL-1:0] hits;
  logic centre_black;

  // window after shifting in the new column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3 + 0] = win[r*3 + 1];
      win_next[r*3 + 1] = win[r*3 + 2];
    end
    win_next[2] = col_top;
    win_next[5] = col_mid;
    win_next[8] = col_bot;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win <= win_next;
    end
  end

  // template compares on the shifted window
  always_comb begin
    for (int t = 0; t < hmt_pkg::NUM_TPL; t++) begin
      hits[t] = hmt_pkg::tpl_hit(tpls[t], win_next);
    end
  end

  assign centre_black = interior && (win_next[4] == hmt_pkg::BLACK);

  // black interior center stays black unless a template hits; every other center is white
  always_comb begin
    result.remove = centre_black && (|hits);
    result.pixel  = (centre_black && !(|hits)) ? hmt_pkg::BLACK : hmt_pkg::WHITE;
  end

endmodule

### rtl/hmt_port_checker.sv
// port-level checks of the thinning pass, bound to the top level
// depends on hmt_pkg and hit_or_miss_thinning_pass_macros.svh
`include "hit_or_miss_thinning_pass_macros.svh"

module hmt_port_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input hmt_pkg::pix_t pixel_out,
  input logic          frame_done,
  input logic          any_removed
);

  // a stalled result holds
  `HMT_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(frame_done) && $stable(any_removed), "result changed while stalled")

  // results are pure black or white
  `HMT_ASSERT(a_out_binary, clk, rst, out_valid |-> pixel_out == 8'd0 || pixel_out == 8'd255, "result pixel is grey")

  // the removal flag rides only on the end of a frame
  `HMT_ASSERT(a_removed_on_done, clk, rst, out_valid && any_removed |-> frame_done, "any_removed without frame_done")

  // input backs up only behind a stalled result
  `HMT_ASSERT(a_stall_cause, clk, rst, in_stall |-> out_valid && out_stall, "input stalled with free output")

  // no result right after reset
  `HMT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind hit_or_miss_thinning_pass hmt_port_checker u_port_checker (.*);
